[sv/sbpd_pkg.sv]
// Shared types and constants for the six-bit blob packet decoder.
// No dependencies; every other file except sbpd_ram refers to this package by scoped names.
`default_nettype none

package sbpd_pkg;

    localparam int CHANNELS = 32;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TOT_W    = $clog2(CHANNELS * 65535 + 1);
    localparam int CHAN_W   = 5;
    localparam int QDEPTH   = 2;
    localparam int QAW      = $clog2(QDEPTH);
    localparam int RANGE_W  = 32;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_BLOB   = 1'b1;

    typedef enum logic {
        PH_HEADER,
        PH_BLOBS
    } phase_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SEARCH,
        B_HOLD
    } back_state_t;

    typedef struct packed {
        logic              kind;
        logic              last;
        logic              lookup;
        logic [TOT_W-1:0]  number;
        logic [31:0]       f0;
        logic [5:0][15:0]  fv;
    } item_t;

    typedef struct packed {
        logic              kind;
        logic              last;
        logic [CHAN_W-1:0] channel;
        logic [15:0]       first_index;
        logic [15:0]       blob_count;
        logic [31:0]       area;
        logic [15:0]       center_x;
        logic [15:0]       center_y;
        logic [15:0]       left_edge;
        logic [15:0]       right_edge;
        logic [15:0]       top_edge;
        logic [15:0]       bottom_edge;
    } result_t;

endpackage

`default_nettype wire

[sv/sbpd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sbpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/sbpd_front.sv]
// Byte front end: tracks frame position, assembles six-bit digits into fields
// and pushes one work item per finished header entry or blob record. Uses sbpd_pkg.
`default_nettype none

module sbpd_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          mode_new,
    input  wire logic          accept,
    input  wire logic [7:0]    byte_value,
    input  wire logic          start_of_frame,
    output logic               push,
    output sbpd_pkg::item_t    push_item
);

    sbpd_pkg::phase_t               phase_reg, phase_next, ph;
    logic [3:0]                     pos_reg, pos_next, p;
    logic [sbpd_pkg::TOT_W-1:0]     num_reg, num_next, nb;
    logic [sbpd_pkg::TOT_W-1:0]     total_reg, total_next, tb, tot_sum;
    logic [31:0]                    acc_reg, acc_next;
    logic [31:0]                    f0_reg, f0_next;
    logic [5:0][15:0]               fv_reg, fv_next;
    logic [31:0]                    d, cmb;
    logic [4:0]                     len;
    logic [3:0]                     q;
    logic                           done, hdr_end, blob_end;

    always_comb begin
        d   = {24'd0, byte_value} - 32'd1;
        cmb = {acc_reg[25:0], 6'd0} | d;
        ph  = start_of_frame ? sbpd_pkg::PH_HEADER : phase_reg;
        p   = start_of_frame ? 4'd0 : pos_reg;
        nb  = start_of_frame ? '0 : num_reg;
        tb  = start_of_frame ? '0 : total_reg;
        q   = p - 4'd4;

        acc_next = acc_reg;
        f0_next  = (p == 4'd0) ? 32'd0 : f0_reg;
        fv_next  = (p == 4'd0) ? '0 : fv_reg;

        if (ph == sbpd_pkg::PH_HEADER) begin
            len = mode_new ? 5'd4 : 5'd2;
            if (!mode_new) begin
                if (p == 4'd0) begin
                    f0_next = {16'd0, d[15:0]};
                end else if (p == 4'd1) begin
                    fv_next[0] = d[15:0];
                end
            end else if (p < 4'd4) begin
                if (!p[0]) begin
                    acc_next = d;
                end else if (!p[1]) begin
                    f0_next = {16'd0, cmb[15:0]};
                end else begin
                    fv_next[0] = cmb[15:0];
                end
            end
        end else begin
            len = mode_new ? 5'd16 : 5'd10;
            if (p < 4'd4) begin
                acc_next = (p == 4'd0) ? d : cmb;
                if (p == 4'd3) begin
                    f0_next = cmb;
                end
            end else if (!mode_new) begin
                if (p < 4'd10) begin
                    fv_next[q[2:0]] = d[15:0];
                end
            end else begin
                if (!q[0]) begin
                    acc_next = d;
                end else begin
                    fv_next[q[3:1]] = cmb[15:0];
                end
            end
        end

        done     = ({1'b0, p} + 5'd1) >= len;
        tot_sum  = tb + sbpd_pkg::TOT_W'(fv_next[0]);
        hdr_end  = (nb + 1'b1) >= sbpd_pkg::TOT_W'(sbpd_pkg::CHANNELS);
        blob_end = (nb + 1'b1) >= tb;

        push_item.kind   = (ph == sbpd_pkg::PH_HEADER) ? sbpd_pkg::KIND_HEADER
                                                       : sbpd_pkg::KIND_BLOB;
        push_item.last   = (ph == sbpd_pkg::PH_HEADER) ? (hdr_end && (tot_sum == '0))
                                                       : blob_end;
        push_item.lookup = mode_new;
        push_item.number = nb;
        push_item.f0     = f0_next;
        push_item.fv     = fv_next;
        push             = accept && done;

        pos_next   = p + 4'd1;
        phase_next = ph;
        num_next   = nb;
        total_next = tb;
        if (done) begin
            pos_next = 4'd0;
            if (ph == sbpd_pkg::PH_HEADER) begin
                total_next = tot_sum;
                num_next   = nb + 1'b1;
                if (hdr_end) begin
                    num_next = '0;
                    if (tot_sum == '0) begin
                        phase_next = sbpd_pkg::PH_HEADER;
                    end else begin
                        phase_next = sbpd_pkg::PH_BLOBS;
                    end
                end
            end else begin
                num_next = nb + 1'b1;
                if (blob_end) begin
                    phase_next = sbpd_pkg::PH_HEADER;
                    num_next   = '0;
                    total_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sbpd_pkg::PH_HEADER;
            pos_reg   <= 4'd0;
            num_reg   <= '0;
            total_reg <= '0;
            acc_reg   <= 32'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            num_reg   <= num_next;
            total_reg <= total_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f0_reg <= f0_next;
            fv_reg <= fv_next;
        end
    end

endmodule

`default_nettype wire

[sv/sbpd_queue.sv]
// Short FIFO of work items between the front end and the back end.
// Uses sbpd_pkg.
`default_nettype none

module sbpd_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire sbpd_pkg::item_t  push_item,
    output logic                  full,
    input  wire logic             pop,
    output sbpd_pkg::item_t       pop_item,
    output logic                  not_empty
);

    sbpd_pkg::item_t          slot_reg [sbpd_pkg::QDEPTH];
    logic [sbpd_pkg::QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [sbpd_pkg::QAW:0]   count_reg, count_next;

    assign full      = (count_reg == (sbpd_pkg::QAW+1)'(sbpd_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[sv/sbpd_back.sv]
// Back end: records header ranges in the range RAM, scans it for a new-format
// blob's channel and drives the result register. Uses sbpd_pkg and sbpd_ram.
`default_nettype none

module sbpd_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire sbpd_pkg::item_t  q_item,
    input  wire logic             q_valid,
    output logic                  q_pop,
    output logic                  m_valid,
    output sbpd_pkg::result_t     m_result,
    input  wire logic             m_ready
);

    localparam logic [sbpd_pkg::CH_W-1:0] LAST_CH = sbpd_pkg::CH_W'(sbpd_pkg::CHANNELS - 1);

    sbpd_pkg::back_state_t          state_reg, state_next;
    sbpd_pkg::item_t                item_reg;
    logic [sbpd_pkg::CH_W-1:0]      scan_reg, chk_reg;
    logic [sbpd_pkg::CHAN_W-1:0]    chan_reg;
    logic                           rd_valid_reg;
    logic                           m_valid_reg;
    sbpd_pkg::result_t              m_result_reg;

    logic                           slot_free, load;
    sbpd_pkg::result_t              res;
    logic                           ram_we;
    logic [sbpd_pkg::RANGE_W-1:0]   ram_rdata;
    logic [16:0]                    range_end;
    logic                           match, found, ended;

    function automatic sbpd_pkg::result_t blob_result(sbpd_pkg::item_t it,
                                                      logic [sbpd_pkg::CHAN_W-1:0] ch);
        sbpd_pkg::result_t r;
        r.kind        = sbpd_pkg::KIND_BLOB;
        r.last        = it.last;
        r.channel     = ch;
        r.first_index = 16'd0;
        r.blob_count  = 16'd0;
        r.area        = it.f0;
        r.center_x    = it.fv[0];
        r.center_y    = it.fv[1];
        r.left_edge   = it.fv[2];
        r.right_edge  = it.fv[3];
        r.top_edge    = it.fv[4];
        r.bottom_edge = it.fv[5];
        return r;
    endfunction

    sbpd_ram #(
        .WIDTH(sbpd_pkg::RANGE_W),
        .DEPTH(sbpd_pkg::CHANNELS)
    ) u_ranges (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (q_item.number[sbpd_pkg::CH_W-1:0]),
        .wdata ({q_item.fv[0], q_item.f0[15:0]}),
        .raddr (scan_reg),
        .rdata (ram_rdata)
    );

    assign slot_free = !m_valid_reg || m_ready;
    assign range_end = {1'b0, ram_rdata[15:0]} + {1'b0, ram_rdata[31:16]};
    assign match     = (item_reg.number >= sbpd_pkg::TOT_W'(ram_rdata[15:0]))
                    && (item_reg.number < sbpd_pkg::TOT_W'(range_end));
    assign found     = rd_valid_reg && match;
    assign ended     = rd_valid_reg && (chk_reg == LAST_CH);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sbpd_pkg::B_IDLE: begin
                if (q_valid && slot_free && (q_item.kind == sbpd_pkg::KIND_BLOB)
                        && q_item.lookup) begin
                    state_next = sbpd_pkg::B_SEARCH;
                end
            end
            sbpd_pkg::B_SEARCH: begin
                if (found || ended) begin
                    state_next = sbpd_pkg::B_HOLD;
                end
            end
            sbpd_pkg::B_HOLD: begin
                if (slot_free) begin
                    state_next = sbpd_pkg::B_IDLE;
                end
            end
            default: state_next = sbpd_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        q_pop  = 1'b0;
        ram_we = 1'b0;
        load   = 1'b0;
        res    = blob_result(item_reg, chan_reg);
        unique case (state_reg)
            sbpd_pkg::B_IDLE: begin
                if (q_valid && slot_free) begin
                    q_pop = 1'b1;
                    if (q_item.kind == sbpd_pkg::KIND_HEADER) begin
                        ram_we          = 1'b1;
                        load            = 1'b1;
                        res             = '0;
                        res.kind        = sbpd_pkg::KIND_HEADER;
                        res.last        = q_item.last;
                        res.channel     = q_item.number[sbpd_pkg::CHAN_W-1:0];
                        res.first_index = q_item.f0[15:0];
                        res.blob_count  = q_item.fv[0];
                    end else if (!q_item.lookup) begin
                        load = 1'b1;
                        res  = blob_result(q_item, '0);
                    end
                end
            end
            sbpd_pkg::B_SEARCH: begin
                load = 1'b0;
            end
            sbpd_pkg::B_HOLD: begin
                load = slot_free;
            end
            default: load = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sbpd_pkg::B_IDLE;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == sbpd_pkg::B_SEARCH) && !found && !ended;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
        end
        if (state_reg != sbpd_pkg::B_SEARCH) begin
            scan_reg <= '0;
        end else if (scan_reg != LAST_CH) begin
            scan_reg <= scan_reg + 1'b1;
        end
        chk_reg <= scan_reg;
        if (found) begin
            chan_reg <= sbpd_pkg::CHAN_W'(chk_reg);
        end else if (ended) begin
            chan_reg <= '0;
        end
        if (load) begin
            m_result_reg <= res;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

`default_nettype wire

[sv/sixbit_blob_packet_decoder_core.sv]
// Six-bit blob packet decoder, top level: configuration register, front end,
// work queue and back end. Uses sbpd_pkg, sbpd_front, sbpd_queue and sbpd_back.
//
// Usage: frame bytes enter on the s_ stream, one byte per transaction, with
// s_tuser marking the first byte of a frame. Each finished header entry and
// each finished blob record leaves as one transaction on the m_ stream;
// m_tuser is the kind (header entry or blob) and m_tlast flags the final
// result of the frame. cfg_wr_en/cfg_wr_data set the format (0 old, 1 new)
// between frames or while the block is idle.
// Path: a header entry or an old-format blob passes through the work queue
// into the result register. A new-format blob scans the channel range RAM
// one entry per cycle until it finds its channel or reaches the last entry.
// Throughput: one byte per cycle while the two-item work queue has room; a
// new-format blob occupies the back end until its scan ends and it is loaded.
// Reset: aresetn low clears frame tracking, the queue and the result valid
// flag and selects the old format; the next byte starts a frame. A stalled
// receiver holds m_ data steady; the queue then fills and s_tready drops.
`default_nettype none

module sixbit_blob_packet_decoder_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [0:0]    cfg_wr_data,  // [0] format_mode
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,      // [7:0] byte_value
    input  wire logic [0:0]    s_tuser,      // [0] start_of_frame
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // [4:0] channel, [20:5] first_index, [36:21] blob_count, [68:37] area,
    // [84:69] center_x, [100:85] center_y, [116:101] left_edge,
    // [132:117] right_edge, [148:133] top_edge, [164:149] bottom_edge,
    // [167:165] zero
    output logic [167:0]       m_tdata,
    output logic [0:0]         m_tuser,      // [0] kind
    output logic               m_tlast
);

    logic                mode_reg;
    logic                accept, push, q_full, q_pop, q_valid;
    sbpd_pkg::item_t     push_item, q_item;
    sbpd_pkg::result_t   res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data[0];
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    sbpd_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .mode_new       (mode_reg),
        .accept         (accept),
        .byte_value     (s_tdata),
        .start_of_frame (s_tuser[0]),
        .push           (push),
        .push_item      (push_item)
    );

    sbpd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .not_empty (q_valid)
    );

    sbpd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_result (res),
        .m_ready  (m_tready)
    );

    assign m_tdata = {3'd0, res.bottom_edge, res.top_edge, res.right_edge, res.left_edge,
                      res.center_y, res.center_x, res.area, res.blob_count,
                      res.first_index, res.channel};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

`default_nettype wire
